// File: rtl/ma_pkg.sv
// Shared constants for the moving average block.
// No dependencies; imported by ma_front, ma_div, moving_average and ma_checker.
package ma_pkg;

  localparam int DATA_W         = 32;
  localparam int WLEN_W         = 8;
  localparam int MAX_WINDOW_DEF = 128;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [WLEN_W-1:0] WLEN_RESET = WLEN_W'(100);

endpackage

// File: rtl/ma_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing; used for the sample history ring.
module ma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: rtl/ma_queue.sv
// Short register queue between the front end and the divider.
// Depends on ma_pkg for nothing but is kept generic in width and depth.
module ma_queue #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [WIDTH-1:0] rdata_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] data_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = data_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      data_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// File: rtl/ma_front.sv
// Front end: takes samples, keeps the history ring, running sum and count.
// Depends on ma_pkg and ma_ram; hands (sum, count) jobs to the queue.
module ma_front
  import ma_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF,
  parameter int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1,
  parameter int CNT_W = $clog2(MAX_WINDOW + 1),
  parameter int SUM_W = DATA_W + IDX_W + 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [WLEN_W-1:0] cfg_wdata_i,
  input  logic              valid_i,
  output logic              ready_o,
  input  logic [DATA_W-1:0] sample_i,
  input  logic              first_i,
  input  logic              q_full_i,
  output logic              job_valid_o,
  output logic [SUM_W-1:0]  job_sum_o,
  output logic [CNT_W-1:0]  job_cnt_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_UPD  = 1'b1;

  logic                    state_q;
  logic [WLEN_W-1:0]       wlen_q;
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic [CNT_W-1:0]        cnt_q;
  logic [IDX_W-1:0]        slot_q, slot_nxt, old_idx;
  logic [CNT_W-1:0]        win;
  logic                    sub_q;
  logic [DATA_W-1:0]       smp_q;
  logic [DATA_W-1:0]       old_smp;
  logic                    accept;
  int                      old_int;

  // Effective window: zero acts as one, anything past the ring size saturates.
  always_comb begin
    if (wlen_q == '0) begin
      win = CNT_W'(1);
    end else if (32'(wlen_q) > 32'(MAX_WINDOW)) begin
      win = CNT_W'(MAX_WINDOW);
    end else begin
      win = CNT_W'(wlen_q);
    end
  end

  always_comb begin
    if (32'(slot_q) >= 32'(win)) begin
      old_int = int'(slot_q) - int'(win);
    end else begin
      old_int = int'(slot_q) + MAX_WINDOW - int'(win);
    end
    old_idx  = IDX_W'(old_int);
    slot_nxt = (slot_q == IDX_W'(MAX_WINDOW - 1)) ? '0 : slot_q + 1'b1;
  end

  assign ready_o = (state_q == ST_IDLE) && !q_full_i;
  assign accept  = valid_i && ready_o;

  // The oldest sample is read at accept and arrives for the update beat.
  ma_ram #(
    .WIDTH (DATA_W),
    .DEPTH (MAX_WINDOW),
    .ADDR_W(IDX_W)
  ) u_hist (
    .clk_i  (clk_i),
    .we_i   (state_q == ST_UPD),
    .waddr_i(slot_q),
    .wdata_i(smp_q),
    .re_i   (accept),
    .raddr_i(old_idx),
    .rdata_o(old_smp)
  );

  always_comb begin
    sum_d = sum_q + {{(SUM_W - DATA_W){smp_q[DATA_W-1]}}, smp_q};
    if (sub_q) begin
      sum_d = sum_d - {{(SUM_W - DATA_W){old_smp[DATA_W-1]}}, old_smp};
    end
  end

  assign job_valid_o = (state_q == ST_UPD);
  assign job_sum_o   = sum_d;
  assign job_cnt_o   = (cnt_q < win) ? cnt_q + 1'b1 : cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      wlen_q  <= WLEN_RESET;
      sum_q   <= '0;
      cnt_q   <= '0;
      slot_q  <= '0;
      sub_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        wlen_q <= cfg_wdata_i;
        sum_q  <= '0;
        cnt_q  <= '0;
        slot_q <= '0;
      end else if (accept) begin
        state_q <= ST_UPD;
        sub_q   <= !first_i && (cnt_q >= win);
        if (first_i) begin
          sum_q  <= '0;
          cnt_q  <= '0;
          slot_q <= '0;
        end
      end else if (state_q == ST_UPD) begin
        state_q <= ST_IDLE;
        sum_q   <= sum_d;
        cnt_q   <= job_cnt_o;
        slot_q  <= slot_nxt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      smp_q <= sample_i;
    end
  end

endmodule

// File: rtl/ma_div.sv
// Back end: restoring divider of the running sum by the sample count,
// truncating toward zero, with the result register. Depends on ma_pkg.
module ma_div
  import ma_pkg::*;
#(
  parameter int SUM_W = 40,
  parameter int CNT_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_empty_i,
  input  logic [SUM_W-1:0]  job_sum_i,
  input  logic [CNT_W-1:0]  job_cnt_i,
  output logic              job_pop_o,
  output logic              empty_o,
  input  logic              pop_i,
  output logic [DATA_W-1:0] average_o
);

  localparam int ITER_W = $clog2(SUM_W);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]        state_q;
  logic [ITER_W-1:0] iter_q;
  logic [SUM_W-1:0]  aq_q;
  logic [CNT_W-1:0]  rem_q;
  logic [CNT_W-1:0]  dvs_q;
  logic              neg_q;
  logic              out_vld_q;
  logic [CNT_W:0]    rem_sh, rem_sub;
  logic              ge;
  logic [SUM_W-1:0]  quot;
  logic              load_out;

  assign job_pop_o = (state_q == ST_IDLE) && !job_empty_i;

  // One quotient bit per cycle, most significant first.
  assign rem_sh  = {rem_q, aq_q[SUM_W-1]};
  assign ge      = (rem_sh >= {1'b0, dvs_q});
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  assign quot     = neg_q ? (~aq_q + 1'b1) : aq_q;
  assign load_out = (state_q == ST_DONE) && (!out_vld_q || pop_i);
  assign empty_o  = !out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      iter_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (pop_i) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (job_pop_o) begin
            state_q <= ST_RUN;
            iter_q  <= '0;
          end
        end
        ST_RUN: begin
          iter_q <= iter_q + 1'b1;
          if (iter_q == ITER_W'(SUM_W - 1)) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (load_out) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      neg_q <= job_sum_i[SUM_W-1];
      aq_q  <= job_sum_i[SUM_W-1] ? (~job_sum_i + 1'b1) : job_sum_i;
      dvs_q <= job_cnt_i;
      rem_q <= '0;
    end else if (state_q == ST_RUN) begin
      aq_q  <= {aq_q[SUM_W-2:0], ge};
      rem_q <= ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
    end
    if (load_out) begin
      average_o <= quot[DATA_W-1:0];
    end
  end

endmodule

// File: rtl/moving_average.sv
// Channel   Handshake            Payload
// config    cfg_we_i             cfg_wdata_i (window length)
// samples   push / full          sample_i, first_i
// results   empty / pop          average_o
//
// The front end accepts a sample in its idle state, reading the oldest ring
// entry, and updates the running sum in its update state before the next.
// The divider sets the sustained rate, one quotient bit per cycle, and takes
// no new job until its result is loaded. Reset needs no clearing pass; ring
// data is used only where written in this sequence. Either side may stall.
module moving_average
  import ma_pkg::*;
#(
  parameter int MAX_WINDOW = MAX_WINDOW_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [WLEN_W-1:0] cfg_wdata_i,
  input  logic              push,
  output logic              full,
  input  logic [DATA_W-1:0] sample_i,
  input  logic              first_i,
  output logic              empty,
  input  logic              pop,
  output logic [DATA_W-1:0] average_o
);

  localparam int IDX_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int SUM_W = DATA_W + IDX_W + 1;
  localparam int JOB_W = SUM_W + CNT_W;

  logic             in_ready;
  logic             job_valid, q_full, q_empty, q_pop;
  logic [SUM_W-1:0] job_sum;
  logic [CNT_W-1:0] job_cnt;
  logic [JOB_W-1:0] q_rdata;

  assign full = !in_ready;

  ma_front #(
    .MAX_WINDOW(MAX_WINDOW),
    .IDX_W     (IDX_W),
    .CNT_W     (CNT_W),
    .SUM_W     (SUM_W)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .valid_i    (push),
    .ready_o    (in_ready),
    .sample_i   (sample_i),
    .first_i    (first_i),
    .q_full_i   (q_full),
    .job_valid_o(job_valid),
    .job_sum_o  (job_sum),
    .job_cnt_o  (job_cnt)
  );

  ma_queue #(
    .WIDTH(JOB_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_valid),
    .wdata_i({job_sum, job_cnt}),
    .full_o (q_full),
    .pop_i  (q_pop),
    .empty_o(q_empty),
    .rdata_o(q_rdata)
  );

  ma_div #(
    .SUM_W(SUM_W),
    .CNT_W(CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_empty_i(q_empty),
    .job_sum_i  (q_rdata[JOB_W-1:CNT_W]),
    .job_cnt_i  (q_rdata[CNT_W-1:0]),
    .job_pop_o  (q_pop),
    .empty_o    (empty),
    .pop_i      (pop),
    .average_o  (average_o)
  );

endmodule

// File: rtl/ma_checker.sv
// Port-level checks for moving_average, attached by the bind below.
// Depends on ma_pkg.
module ma_checker
  import ma_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              push,
  input logic              full,
  input logic              empty,
  input logic              pop,
  input logic [DATA_W-1:0] average_o
);

  // The front end reports full while it updates the sum for an accepted sample.
  a_busy_after_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !full |=> full)
    else $error("full low right after an accepted beat");

  // A result cannot appear in the cycle after its sample; the divider is slower.
  a_no_instant_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty && push && !full |=> empty)
    else $error("result appeared one cycle after its input beat");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty)
    else $error("waiting result dropped without pop");

  a_result_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> $stable(average_o))
    else $error("waiting result changed without pop");

endmodule

bind moving_average ma_checker u_ma_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .push     (push),
  .full     (full),
  .empty    (empty),
  .pop      (pop),
  .average_o(average_o)
);
